### rtl/bez_pkg.sv
// bez_pkg: shared constants, widths and control structs of the bezier easing block
`timescale 1ns / 1ps

package bez_pkg;

  // search depth and output precision
  localparam int BISECT_STEPS  = 12;
  localparam int FRACTION_BITS = 16;

  // field widths
  localparam int CTRL_W   = 7;
  localparam int CTRL_MAX = 127;
  localparam int TIME_W   = FRACTION_BITS + 1;

  // curve parameter s in units of 2^-POS_BITS, r = 1 - s needs one more bit
  localparam int POS_BITS = BISECT_STEPS + 1;
  localparam int RW       = POS_BITS + 1;

  // evaluation chain widths
  localparam int SR_W  = POS_BITS + RW;
  localparam int U_W   = CTRL_W + RW;
  localparam int W_W   = U_W + 1;
  localparam int SS_W  = 2 * POS_BITS;
  localparam int SSS_W = 3 * POS_BITS;
  localparam int K_W   = SSS_W + CTRL_W;
  localparam int P_W   = SR_W + W_W;
  localparam int N_W   = 3 * POS_BITS + 9;

  // rounding of N / (127 * 2^(3*POS_BITS)) to Q1.FRACTION_BITS
  localparam int SH    = 3 * POS_BITS - FRACTION_BITS;
  localparam int SH_R  = (SH > 0) ? SH : 0;
  localparam int SH_L  = (SH > 0) ? 0 : -SH;
  localparam int SH_R1 = (SH > 1) ? SH - 1 : 0;
  localparam longint unsigned RND = (SH > 0) ?
      longint'(CTRL_MAX) * (longint'(1) << SH_R1) : longint'(CTRL_MAX / 2);

  // division by 127 as multiplication by a rounded-up reciprocal
  localparam int AP_W  = FRACTION_BITS + 8;
  localparam int RCP_E = AP_W + 7;
  localparam int RCP_W = AP_W + 1;
  localparam int MUL_W = AP_W + RCP_W;
  localparam longint unsigned RCP = ((longint'(1) << RCP_E) + CTRL_MAX - 1) / CTRL_MAX;
  localparam int X_W   = FRACTION_BITS + 2;

  // sequencing
  localparam int EVAL_CYCLES = 6;
  localparam int PH_W        = $clog2(EVAL_CYCLES);
  localparam int ITER_W      = $clog2(BISECT_STEPS + 1);

  localparam logic [TIME_W-1:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};

  // controller to datapath
  typedef struct packed {
    logic load;
    logic use_y;
    logic move;
    logic res_load;
  } bez_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ident;
    logic x_eq;
    logic t_le;
  } bez_status_t;

endpackage

### rtl/bez_in_if.sv
// bez_in_if: input channel carrying time fraction and control points
`timescale 1ns / 1ps

interface bez_in_if;
  import bez_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_fraction;
  logic [CTRL_W-1:0] ctrl_ax;
  logic [CTRL_W-1:0] ctrl_ay;
  logic [CTRL_W-1:0] ctrl_bx;
  logic [CTRL_W-1:0] ctrl_by;

  modport source (
    output valid, time_fraction, ctrl_ax, ctrl_ay, ctrl_bx, ctrl_by,
    input  ready
  );

  modport sink (
    input  valid, time_fraction, ctrl_ax, ctrl_ay, ctrl_bx, ctrl_by,
    output ready
  );
endinterface

### rtl/bez_out_if.sv
// bez_out_if: output channel carrying the eased fraction
`timescale 1ns / 1ps

interface bez_out_if;
  import bez_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] eased_fraction;

  modport source (
    output valid, eased_fraction,
    input  ready
  );

  modport sink (
    input  valid, eased_fraction,
    output ready
  );
endinterface

### rtl/bez_dpath.sv
// bez_dpath: operand registers, curve evaluation chain, bisection update and result register
`timescale 1ns / 1ps

module bez_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bez_pkg::bez_cmd_t           cmd_i,
  input  logic [bez_pkg::TIME_W-1:0]  time_fraction_i,
  input  logic [bez_pkg::CTRL_W-1:0]  ctrl_ax_i,
  input  logic [bez_pkg::CTRL_W-1:0]  ctrl_ay_i,
  input  logic [bez_pkg::CTRL_W-1:0]  ctrl_bx_i,
  input  logic [bez_pkg::CTRL_W-1:0]  ctrl_by_i,
  output bez_pkg::bez_status_t        status_o,
  output logic [bez_pkg::TIME_W-1:0]  eased_fraction_o
);
  import bez_pkg::*;

  localparam logic [POS_BITS-1:0] S_INIT    = {1'b1, {(POS_BITS-1){1'b0}}};
  localparam logic [POS_BITS-1:0] STEP_INIT = S_INIT >> 1;
  localparam int                  APX_W     = N_W + SH_L + 1;

  logic [TIME_W-1:0]   t_q;
  logic [CTRL_W-1:0]   ax_q, ay_q, bx_q, by_q;
  logic [POS_BITS-1:0] s_q, step_q;
  logic [RW-1:0]       r;
  logic [CTRL_W-1:0]   coef_a, coef_b;
  logic [SR_W-1:0]     sr_q;
  logic [U_W-1:0]      u_q, v_q;
  logic [SS_W-1:0]     ss_q;
  logic [W_W-1:0]      w_q;
  logic [SSS_W-1:0]    sss_q;
  logic [P_W-1:0]      p_q;
  logic [K_W-1:0]      k_q;
  logic [N_W-1:0]      n_q;
  logic [APX_W-1:0]    ap_full;
  logic [AP_W-1:0]     ap_q;
  logic [MUL_W-1:0]    xp;
  logic [X_W-1:0]      x_q;
  logic [TIME_W-1:0]   y_sat;
  logic [TIME_W-1:0]   res_q;

  // operands of the curve under evaluation
  assign r      = {1'b1, {POS_BITS{1'b0}}} - {1'b0, s_q};
  assign coef_a = cmd_i.use_y ? ay_q : ax_q;
  assign coef_b = cmd_i.use_y ? by_q : bx_q;

  // input capture, clamped to one
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q  <= (time_fraction_i > ONE_Q) ? ONE_Q : time_fraction_i;
      ax_q <= ctrl_ax_i;
      ay_q <= ctrl_ay_i;
      bx_q <= ctrl_bx_i;
      by_q <= ctrl_by_i;
    end
  end

  // bisection position and step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q    <= S_INIT;
      step_q <= STEP_INIT;
    end else if (cmd_i.load) begin
      s_q    <= S_INIT;
      step_q <= STEP_INIT;
    end else if (cmd_i.move) begin
      s_q    <= status_o.t_le ? s_q - step_q : s_q + step_q;
      step_q <= step_q >> 1;
    end
  end

  // rounding and reciprocal product
  assign ap_full = (APX_W'(n_q) << SH_L) + APX_W'(RND);
  assign xp      = MUL_W'(ap_q) * MUL_W'(RCP);

  // evaluation chain, x(s) settles in x_q while s is held
  always_ff @(posedge clk_i) begin
    sr_q  <= SR_W'(s_q) * SR_W'(r);
    u_q   <= U_W'(coef_a) * U_W'(r);
    v_q   <= U_W'(coef_b) * U_W'(s_q);
    ss_q  <= SS_W'(s_q) * SS_W'(s_q);
    w_q   <= W_W'(u_q) + W_W'(v_q);
    sss_q <= SSS_W'(ss_q) * SSS_W'(s_q);
    p_q   <= P_W'(sr_q) * P_W'(w_q);
    k_q   <= (K_W'(sss_q) << CTRL_W) - K_W'(sss_q);
    n_q   <= (N_W'(p_q) << 1) + N_W'(p_q) + N_W'(k_q);
    ap_q  <= AP_W'(ap_full >> SH_R);
    x_q   <= xp[RCP_E +: X_W];
  end

  // comparisons for the controller
  assign status_o.ident = (ax_q == ay_q) && (bx_q == by_q);
  assign status_o.x_eq  = (X_W'(t_q) == x_q);
  assign status_o.t_le  = (X_W'(t_q) <= x_q);

  // result register feeding the output channel
  assign y_sat = (x_q > X_W'(ONE_Q)) ? ONE_Q : x_q[TIME_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q <= status_o.ident ? t_q : y_sat;
    end
  end

  assign eased_fraction_o = res_q;

  // step stays a single power of two until it runs out
  a_step_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(step_q))
    else $error("bisection step is not a power of two");

  // a move never drives s to zero
  a_s_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move |=> (s_q != '0))
    else $error("bisection position reached zero");

endmodule

### rtl/bez_ctrl.sv
// bez_ctrl: sequencer for load, bisection steps, final y evaluation and output handoff
`timescale 1ns / 1ps

module bez_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bez_pkg::bez_status_t status_i,
  output bez_pkg::bez_cmd_t    cmd_o
);
  import bez_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              use_y_q, use_y_d;
  logic              out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    iter_d      = iter_q;
    use_y_d     = use_y_q;
    cmd_o       = '0;
    cmd_o.use_y = use_y_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          use_y_d    = 1'b0;
          iter_d     = '0;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        phase_d = '0;
        state_d = status_i.ident ? ST_DONE : ST_EVAL;
      end
      ST_EVAL: begin
        if (phase_q == PH_W'(EVAL_CYCLES - 1)) begin
          state_d = ST_DECIDE;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        phase_d = '0;
        if (use_y_q) begin
          state_d = ST_DONE;
        end else if (status_i.x_eq) begin
          // exact hit ends the search early
          use_y_d = 1'b1;
          state_d = ST_EVAL;
        end else begin
          cmd_o.move = 1'b1;
          state_d    = ST_EVAL;
          if (iter_q == ITER_W'(BISECT_STEPS - 1)) begin
            use_y_d = 1'b1;
          end else begin
            iter_d = iter_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      iter_q      <= '0;
      use_y_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      iter_q      <= iter_d;
      use_y_q     <= use_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // an accepted transaction always starts a new solve
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_START))
    else $error("accepted transaction did not start a solve");

  // step counter stays within the search depth
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (iter_q <= ITER_W'(BISECT_STEPS - 1)))
    else $error("bisection step counter out of range");

  // a loaded result is presented and the block is free again
  a_res_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> (out_valid_o && (state_q == ST_IDLE)))
    else $error("result load did not raise output valid");

endmodule

### rtl/bezier_easing_bisection_top.sv
// bezier_easing_bisection_top: cubic bezier easing solver, controller plus datapath
`timescale 1ns / 1ps

// Maps a linear time fraction t (unsigned Q1.16, clamped to 1.0) through a cubic
// bezier easing curve with control points (ax,ay) and (bx,by), each given as value/127.
// Identity curves (ax==ay and bx==by) return the clamped t. Otherwise 12 bisection
// steps find s with x(s) close to t, stopping early on an exact match, and y(s) is
// returned rounded to Q1.16 and saturated at 1.0. One transaction is worked at a time.
// Each curve evaluation runs through a six-register multiply and round chain and a
// decision state, and a solve needs up to 13 evaluations between its start and
// handoff states. The result sits in an output register, so the next transaction
// is accepted while an earlier result still waits to be taken.
module bezier_easing_bisection_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  bez_in_if.sink           in_i,
  bez_out_if.source        out_o
);
  import bez_pkg::*;

  bez_cmd_t    cmd;
  bez_status_t status;

  // sequencer
  bez_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and result register
  bez_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .time_fraction_i  (in_i.time_fraction),
    .ctrl_ax_i        (in_i.ctrl_ax),
    .ctrl_ay_i        (in_i.ctrl_ay),
    .ctrl_bx_i        (in_i.ctrl_bx),
    .ctrl_by_i        (in_i.ctrl_by),
    .status_o         (status),
    .eased_fraction_o (out_o.eased_fraction)
  );

endmodule
